[rtl/stpe_pkg.sv]
// ============================================================================
// Simplex tableau pivot engine package
// Shared sizes, codes, payload types and helper functions.
// ============================================================================
package stpe_pkg;

    localparam int MAX_ROWS  = 8;
    localparam int MAX_COLS  = 8;
    localparam int FRAC_BITS = 16;

    localparam int STRIDE = MAX_COLS + 2;
    localparam int DEPTH  = (MAX_ROWS + 1) * STRIDE;
    localparam int ADDR_W = $clog2(DEPTH);

    // Effective row and column counts, and loop counters that run one past them.
    localparam int NR_W  = $clog2(MAX_ROWS + 1);
    localparam int NC_W  = $clog2(MAX_COLS + 1);
    localparam int ROW_W = $clog2(MAX_ROWS + 2);
    localparam int COL_W = $clog2(STRIDE);

    // Serial divider: dividend is |a| << FRAC_BITS plus half the divisor.
    localparam int NUM_W  = 32 + FRAC_BITS;
    localparam int DVD_W  = NUM_W + 1;
    localparam int DCNT_W = $clog2(DVD_W + 1);

    // Product rounding and accumulate widths.
    localparam int PROD_W = 64;
    localparam int RND_W  = PROD_W + 1 - FRAC_BITS;
    localparam int SUM_W  = RND_W + 2;

    localparam logic [0:0] CFG_ROWS = 1'b0;
    localparam logic [0:0] CFG_COLS = 1'b1;

    typedef enum logic [1:0] {
        FUNC_WRITE = 2'd0,
        FUNC_READ  = 2'd1,
        FUNC_FIND  = 2'd2,
        FUNC_PIVOT = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_ZERO_PIVOT = 2'd1,
        ST_NO_ROW     = 2'd2,
        ST_SATURATED  = 2'd3
    } status_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_WRITE,
        S_READ,
        S_READ_WAIT,
        S_FC_RD,
        S_FC_EV,
        S_FR_RD0,
        S_FR_RD1,
        S_FR_EV,
        S_FR_M1,
        S_FR_M2,
        S_FR_M3,
        S_FIN_FIND,
        S_PV_CHK,
        S_PV_P,
        S_PR_RD,
        S_PR_START,
        S_PR_DIV,
        S_RW_NEXT,
        S_RW_H,
        S_RW_RD,
        S_RW_M,
        S_RW_WR,
        S_FIN_PV,
        S_DONE
    } core_state_t;

    typedef struct packed {
        func_t              func;
        logic [3:0]         row_index;
        logic [3:0]         col_index;
        logic signed [31:0] write_value;
    } cmd_t;

    typedef struct packed {
        logic signed [31:0] read_value;
        logic [2:0]         pivot_row;
        logic [3:0]         pivot_col;
        status_t            status;
    } rsp_t;

    typedef struct packed {
        logic               start;
        logic signed [31:0] dividend;
        logic signed [31:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] quot;
        logic        sat;
    } div_rsp_t;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
    } mul_req_t;

    typedef struct packed {
        logic busy;
        logic res_valid;
    } core_stat_t;

    function automatic logic [31:0] mag32(logic signed [31:0] x);
        logic [31:0] t;
        t = x[31] ? (32'd0 - x) : x;
        return t;
    endfunction

    function automatic logic [31:0] mag33(logic signed [32:0] x);
        logic [32:0] t;
        t = x[32] ? (33'd0 - x) : x;
        return t[31:0];
    endfunction

    function automatic logic [NR_W-1:0] eff_rows(logic [3:0] v);
        logic [NR_W-1:0] r;
        if (v == 4'd0) r = NR_W'(1);
        else if (int'(v) > MAX_ROWS) r = NR_W'(MAX_ROWS);
        else r = NR_W'(v);
        return r;
    endfunction

    function automatic logic [NC_W-1:0] eff_cols(logic [3:0] v);
        logic [NC_W-1:0] r;
        if (v == 4'd0) r = NC_W'(1);
        else if (int'(v) > MAX_COLS) r = NC_W'(MAX_COLS);
        else r = NC_W'(v);
        return r;
    endfunction

    function automatic logic [ADDR_W-1:0] tab_addr(int r, int c);
        return ADDR_W'(r * STRIDE + c);
    endfunction

endpackage

[rtl/stpe_mul.sv]
// ============================================================================
// Shared multiplier
// Unsigned 32 x 32 product with the result registered.
// ============================================================================
module stpe_mul
    import stpe_pkg::*;
(
    input  logic                clk,
    input  mul_req_t            req,
    output logic [PROD_W-1:0]   prod
);

    logic [PROD_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(req.a) * PROD_W'(req.b);
    end

    assign prod = prod_reg;

endmodule

[rtl/stpe_div.sv]
// ============================================================================
// Serial fixed-point divider
// Rounded (a << FRAC_BITS) / b, one quotient bit a cycle, saturated to 32 bits.
// ============================================================================
module stpe_div
    import stpe_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic              busy_reg;
    logic              done_reg;
    logic [DCNT_W-1:0] cnt_reg;
    logic [DVD_W-1:0]  d_reg;
    logic [31:0]       rem_reg;
    logic [31:0]       den_reg;
    logic              neg_reg;
    logic [31:0]       quot_reg;
    logic              sat_reg;

    logic [32:0]       rem_sh;
    logic              ge;
    logic [32:0]       rem_sub;
    logic [NUM_W-1:0]  num;
    logic              q_big;
    logic [31:0]       q_lo;

    assign rem_sh  = {rem_reg, d_reg[DVD_W-1]};
    assign ge      = rem_sh >= {1'b0, den_reg};
    assign rem_sub = rem_sh - {1'b0, den_reg};
    assign num     = {mag32(req.dividend), {FRAC_BITS{1'b0}}};
    assign q_lo    = d_reg[31:0];

    // The magnitude may reach 2^31 only when the result is negative.
    always_comb
    begin
        if (neg_reg)
            q_big = (d_reg[DVD_W-1:32] != '0) || (d_reg[31] && (d_reg[30:0] != '0));
        else
            q_big = (d_reg[DVD_W-1:31] != '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= DCNT_W'(DVD_W);
            end
            else if (busy_reg)
            begin
                if (cnt_reg != '0)
                    cnt_reg <= cnt_reg - 1'b1;
                else
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            neg_reg <= req.dividend[31] ^ req.divisor[31];
            den_reg <= mag32(req.divisor);
            d_reg   <= {1'b0, num} + DVD_W'(mag32(req.divisor) >> 1);
            rem_reg <= '0;
        end
        else if (busy_reg && (cnt_reg != '0))
        begin
            rem_reg <= ge ? rem_sub[31:0] : rem_sh[31:0];
            d_reg   <= {d_reg[DVD_W-2:0], ge};
        end
        else if (busy_reg)
        begin
            sat_reg <= q_big;
            if (q_big)
                quot_reg <= neg_reg ? 32'h8000_0000 : 32'h7FFF_FFFF;
            else
                quot_reg <= neg_reg ? (32'd0 - q_lo) : q_lo;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;
    assign rsp.sat  = sat_reg;

endmodule

[rtl/stpe_core.sv]
// ============================================================================
// Tableau sequencer
// Holds the tableau memory and steps write, read, find-pivot and pivot.
// ============================================================================
module stpe_core
    import stpe_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             go,
    input  cmd_t             cmd,
    input  logic [NR_W-1:0]  nr,
    input  logic [NC_W-1:0]  nc,
    input  logic             take,
    output rsp_t             res,
    output core_stat_t       stat
);

    core_state_t state_reg, state_next;

    func_t              func_reg, func_next;
    logic [3:0]         ri_reg, ri_next;
    logic [3:0]         ci_reg, ci_next;
    logic [31:0]        wv_reg, wv_next;
    logic [ROW_W-1:0]   row_reg, row_next;
    logic [COL_W-1:0]   col_reg, col_next;
    logic signed [31:0] best_reg, best_next;
    logic [COL_W-1:0]   pcol_reg, pcol_next;
    logic [ROW_W-1:0]   prow_reg, prow_next;
    logic               found_reg, found_next;
    logic signed [31:0] fm_reg, fm_next;
    logic signed [32:0] bn_reg, bn_next;
    logic [31:0]        bd_reg, bd_next;
    logic signed [32:0] cn_reg, cn_next;
    logic [31:0]        cd_reg, cd_next;
    logic signed [64:0] prod1_reg, prod1_next;
    logic signed [31:0] p_reg, p_next;
    logic               sat_reg, sat_next;
    logic signed [31:0] h_reg, h_next;
    logic signed [SUM_W-1:0] q_reg, q_next;
    logic signed [31:0] old_reg, old_next;
    logic signed [31:0] rv_reg, rv_next;
    status_t            status_reg, status_next;

    logic [31:0]        mem [DEPTH];
    logic [DEPTH-1:0]   ent_valid_reg;
    logic [31:0]        rd_data_reg;
    logic               rd_valid_reg;
    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr;
    logic [31:0]        mem_wdata;
    logic [ADDR_W-1:0]  mem_raddr;

    logic [31:0]        copy_reg [STRIDE];
    logic               copy_we;
    logic [31:0]        copy_wdata;

    div_req_t           div_req;
    div_rsp_t           div_rsp;
    mul_req_t           mul_req;
    logic [PROD_W-1:0]  prod;

    logic signed [31:0] rdv;
    int                 hcol;
    logic signed [32:0] fm_ext;
    logic signed [64:0] prod_s_cn;
    logic signed [64:0] prod_s_bn;
    logic [PROD_W:0]    rnd_sum;
    logic [RND_W-1:0]   q_mag;
    logic signed [SUM_W-1:0] q_ext;
    logic signed [SUM_W-1:0] acc;
    logic               acc_sat;
    logic [31:0]        acc_clip;
    logic               copy_neg;

    localparam logic [PROD_W:0] RND_HALF = (PROD_W + 1)'(1) << (FRAC_BITS - 1);

    // Entries never written since reset read as zero.
    assign rdv  = rd_valid_reg ? $signed(rd_data_reg) : 32'sd0;
    assign hcol = int'(nc) + 1;

    assign fm_ext    = {fm_reg[31], fm_reg};
    assign prod_s_cn = cn_reg[32] ? -$signed({1'b0, prod}) : $signed({1'b0, prod});
    assign prod_s_bn = bn_reg[32] ? -$signed({1'b0, prod}) : $signed({1'b0, prod});

    assign copy_neg = copy_reg[col_reg][31] ^ h_reg[31];
    assign rnd_sum  = {1'b0, prod} + RND_HALF;
    assign q_mag    = rnd_sum[PROD_W:FRAC_BITS];
    assign q_ext    = copy_neg ? -$signed({2'b00, q_mag}) : $signed({2'b00, q_mag});
    assign acc      = q_reg + {{(SUM_W - 32){old_reg[31]}}, old_reg};
    assign acc_sat  = (acc[SUM_W-1:31] != '0) && (acc[SUM_W-1:31] != '1);
    assign acc_clip = acc_sat ? (acc[SUM_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF)
                              : acc[31:0];

    stpe_mul u_mul (
        .clk  (clk),
        .req  (mul_req),
        .prod (prod)
    );

    stpe_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_comb
    begin
        logic signed [31:0] v;
        logic               skip;
        logic signed [32:0] cn;
        logic [31:0]        cd;

        state_next  = state_reg;
        func_next   = func_reg;
        ri_next     = ri_reg;
        ci_next     = ci_reg;
        wv_next     = wv_reg;
        row_next    = row_reg;
        col_next    = col_reg;
        best_next   = best_reg;
        pcol_next   = pcol_reg;
        prow_next   = prow_reg;
        found_next  = found_reg;
        fm_next     = fm_reg;
        bn_next     = bn_reg;
        bd_next     = bd_reg;
        cn_next     = cn_reg;
        cd_next     = cd_reg;
        prod1_next  = prod1_reg;
        p_next      = p_reg;
        sat_next    = sat_reg;
        h_next      = h_reg;
        q_next      = q_reg;
        old_next    = old_reg;
        rv_next     = rv_reg;
        status_next = status_reg;

        mem_we      = 1'b0;
        mem_waddr   = '0;
        mem_wdata   = '0;
        mem_raddr   = '0;
        copy_we     = 1'b0;
        copy_wdata  = '0;
        div_req     = '0;
        mul_req     = '0;

        v    = rdv;
        skip = 1'b0;
        cn   = '0;
        cd   = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (go)
                begin
                    func_next   = cmd.func;
                    ri_next     = cmd.row_index;
                    ci_next     = cmd.col_index;
                    wv_next     = cmd.write_value;
                    rv_next     = '0;
                    prow_next   = '0;
                    pcol_next   = COL_W'(1);
                    col_next    = COL_W'(1);
                    status_next = ST_OK;
                    unique case (cmd.func)
                        FUNC_WRITE: state_next = S_WRITE;
                        FUNC_READ:  state_next = S_READ;
                        FUNC_FIND:  state_next = S_FC_RD;
                        FUNC_PIVOT: state_next = S_PV_CHK;
                    endcase
                end
            end

            S_WRITE:
            begin
                if ((int'(ri_reg) <= int'(nr)) && (int'(ci_reg) <= hcol))
                begin
                    mem_we    = 1'b1;
                    mem_waddr = tab_addr(int'(ri_reg), int'(ci_reg));
                    mem_wdata = wv_reg;
                end
                state_next = S_DONE;
            end

            S_READ:
            begin
                if ((int'(ri_reg) <= int'(nr)) && (int'(ci_reg) <= hcol))
                begin
                    mem_raddr  = tab_addr(int'(ri_reg), int'(ci_reg));
                    state_next = S_READ_WAIT;
                end
                else
                    state_next = S_DONE;
            end

            S_READ_WAIT:
            begin
                rv_next    = rdv;
                state_next = S_DONE;
            end

            S_FC_RD:
            begin
                mem_raddr  = tab_addr(int'(nr), int'(col_reg));
                state_next = S_FC_EV;
            end

            S_FC_EV:
            begin
                if ((col_reg == COL_W'(1)) || (v < best_reg))
                begin
                    best_next = v;
                    pcol_next = col_reg;
                end
                if (int'(col_reg) == int'(nc))
                begin
                    row_next   = '0;
                    found_next = 1'b0;
                    state_next = S_FR_RD0;
                end
                else
                begin
                    col_next   = col_reg + 1'b1;
                    state_next = S_FC_RD;
                end
            end

            S_FR_RD0:
            begin
                if (int'(row_reg) == int'(nr))
                    state_next = S_FIN_FIND;
                else
                begin
                    mem_raddr  = tab_addr(int'(row_reg), 0);
                    state_next = S_FR_RD1;
                end
            end

            S_FR_RD1:
            begin
                fm_next    = rdv;
                mem_raddr  = tab_addr(int'(row_reg), int'(pcol_reg));
                state_next = S_FR_EV;
            end

            S_FR_EV:
            begin
                // A row is passed over when its column entry is zero, or when a
                // positive free term meets a negative column entry.
                skip = (v == 32'sd0) || ((fm_reg > 32'sd0) && (v < 32'sd0));
                cn   = v[31] ? -fm_ext : fm_ext;
                cd   = v[31] ? mag32(v) : v;
                if (skip)
                begin
                    row_next   = row_reg + 1'b1;
                    state_next = S_FR_RD0;
                end
                else if (!found_reg)
                begin
                    found_next = 1'b1;
                    bn_next    = cn;
                    bd_next    = cd;
                    prow_next  = row_reg;
                    row_next   = row_reg + 1'b1;
                    state_next = S_FR_RD0;
                end
                else
                begin
                    cn_next    = cn;
                    cd_next    = cd;
                    state_next = S_FR_M1;
                end
            end

            S_FR_M1:
            begin
                mul_req.a  = mag33(cn_reg);
                mul_req.b  = bd_reg;
                state_next = S_FR_M2;
            end

            S_FR_M2:
            begin
                prod1_next = prod_s_cn;
                mul_req.a  = mag33(bn_reg);
                mul_req.b  = cd_reg;
                state_next = S_FR_M3;
            end

            S_FR_M3:
            begin
                if (prod1_reg < prod_s_bn)
                begin
                    bn_next   = cn_reg;
                    bd_next   = cd_reg;
                    prow_next = row_reg;
                end
                row_next   = row_reg + 1'b1;
                state_next = S_FR_RD0;
            end

            S_FIN_FIND:
            begin
                rv_next = best_reg;
                if (!found_reg)
                begin
                    prow_next   = '0;
                    status_next = ST_NO_ROW;
                end
                state_next = S_DONE;
            end

            S_PV_CHK:
            begin
                if ((int'(ri_reg) < int'(nr)) && (ci_reg != 4'd0)
                    && (int'(ci_reg) <= int'(nc)))
                begin
                    mem_raddr  = tab_addr(int'(ri_reg), int'(ci_reg));
                    state_next = S_PV_P;
                end
                else
                begin
                    status_next = ST_NO_ROW;
                    state_next  = S_DONE;
                end
            end

            S_PV_P:
            begin
                rv_next = rdv;
                if (v == 32'sd0)
                begin
                    status_next = ST_ZERO_PIVOT;
                    state_next  = S_DONE;
                end
                else
                begin
                    p_next     = v;
                    sat_next   = 1'b0;
                    col_next   = '0;
                    state_next = S_PR_RD;
                end
            end

            // The new pivot row is written back as each entry is divided; the old
            // entries to its right are still intact when their turn comes.
            S_PR_RD:
            begin
                if (int'(col_reg) == hcol)
                begin
                    copy_we    = 1'b1;
                    copy_wdata = '0;
                    mem_we     = 1'b1;
                    mem_waddr  = tab_addr(int'(ri_reg), int'(col_reg));
                    mem_wdata  = '0;
                    row_next   = '0;
                    state_next = S_RW_NEXT;
                end
                else if (int'(col_reg) == int'(ci_reg))
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = 32'sd1 <<< FRAC_BITS;
                    div_req.divisor  = p_reg;
                    state_next       = S_PR_DIV;
                end
                else
                begin
                    mem_raddr  = tab_addr(int'(ri_reg), int'(col_reg));
                    state_next = S_PR_START;
                end
            end

            S_PR_START:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = rdv;
                div_req.divisor  = p_reg;
                state_next       = S_PR_DIV;
            end

            S_PR_DIV:
            begin
                if (div_rsp.done)
                begin
                    copy_we    = 1'b1;
                    copy_wdata = div_rsp.quot;
                    mem_we     = 1'b1;
                    mem_waddr  = tab_addr(int'(ri_reg), int'(col_reg));
                    mem_wdata  = div_rsp.quot;
                    sat_next   = sat_reg | div_rsp.sat;
                    col_next   = col_reg + 1'b1;
                    state_next = S_PR_RD;
                end
            end

            S_RW_NEXT:
            begin
                if (int'(row_reg) > int'(nr))
                    state_next = S_FIN_PV;
                else if (int'(row_reg) == int'(ri_reg))
                    row_next = row_reg + 1'b1;
                else
                begin
                    mem_raddr  = tab_addr(int'(row_reg), int'(ci_reg));
                    state_next = S_RW_H;
                end
            end

            S_RW_H:
            begin
                if (v == 32'sh8000_0000)
                begin
                    h_next   = 32'sh7FFF_FFFF;
                    sat_next = 1'b1;
                end
                else
                    h_next = -v;
                col_next   = '0;
                state_next = S_RW_RD;
            end

            S_RW_RD:
            begin
                if (int'(col_reg) == hcol)
                begin
                    mem_we     = 1'b1;
                    mem_waddr  = tab_addr(int'(row_reg), int'(col_reg));
                    mem_wdata  = h_reg;
                    row_next   = row_reg + 1'b1;
                    state_next = S_RW_NEXT;
                end
                else
                begin
                    mem_raddr  = tab_addr(int'(row_reg), int'(col_reg));
                    mul_req.a  = mag32(copy_reg[col_reg]);
                    mul_req.b  = mag32(h_reg);
                    state_next = S_RW_M;
                end
            end

            S_RW_M:
            begin
                q_next     = q_ext;
                old_next   = (int'(col_reg) == int'(ci_reg)) ? 32'sd0 : rdv;
                state_next = S_RW_WR;
            end

            S_RW_WR:
            begin
                mem_we     = 1'b1;
                mem_waddr  = tab_addr(int'(row_reg), int'(col_reg));
                mem_wdata  = acc_clip;
                sat_next   = sat_reg | acc_sat;
                col_next   = col_reg + 1'b1;
                state_next = S_RW_RD;
            end

            S_FIN_PV:
            begin
                status_next = sat_reg ? ST_SATURATED : ST_OK;
                state_next  = S_DONE;
            end

            S_DONE:
            begin
                if (take)
                    state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ent_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            rd_valid_reg <= ent_valid_reg[mem_raddr];
            if (mem_we)
                ent_valid_reg[mem_waddr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg   <= func_next;
        ri_reg     <= ri_next;
        ci_reg     <= ci_next;
        wv_reg     <= wv_next;
        row_reg    <= row_next;
        col_reg    <= col_next;
        best_reg   <= best_next;
        pcol_reg   <= pcol_next;
        prow_reg   <= prow_next;
        found_reg  <= found_next;
        fm_reg     <= fm_next;
        bn_reg     <= bn_next;
        bd_reg     <= bd_next;
        cn_reg     <= cn_next;
        cd_reg     <= cd_next;
        prod1_reg  <= prod1_next;
        p_reg      <= p_next;
        sat_reg    <= sat_next;
        h_reg      <= h_next;
        q_reg      <= q_next;
        old_reg    <= old_next;
        rv_reg     <= rv_next;
        status_reg <= status_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        rd_data_reg <= mem[mem_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (copy_we)
            copy_reg[col_reg] <= copy_wdata;
    end

    always_comb
    begin
        res.read_value = rv_reg;
        res.status     = status_reg;
        if (func_reg == FUNC_PIVOT)
        begin
            res.pivot_row = ri_reg[2:0];
            res.pivot_col = ci_reg;
        end
        else if (func_reg == FUNC_FIND)
        begin
            res.pivot_row = 3'(prow_reg);
            res.pivot_col = 4'(pcol_reg);
        end
        else
        begin
            res.pivot_row = '0;
            res.pivot_col = '0;
        end
    end

    assign stat.busy      = (state_reg != S_IDLE);
    assign stat.res_valid = (state_reg == S_DONE);

endmodule

[rtl/simplex_tableau_pivot_engine_top.sv]
// ============================================================================
// Simplex tableau pivot engine
// Command port, configuration registers and registered response word.
// ============================================================================
// Commands arrive as a word on cmd with cmd_valid and are taken on a clock edge
// where cmd_stall is low. cmd_stall stays high while a command is in progress.
// Every command gives exactly one response word on rsp with rsp_valid, which
// holds until an edge where rsp_stall is low. The response sits in its own
// register, so the next command is taken while an earlier word still waits.
// All commands go through one tableau memory with one read port and one write
// port. The engine returns to idle as the word is presented and can take the
// next command in the following cycle. Pivot is dominated by the serial
// divider, which yields one quotient bit a cycle.
// Configuration writes (cfg_we, cfg_index, cfg_data) are taken at once and
// should only be issued while the engine is idle.
// Reset clears the tableau to zero at once through per-entry valid bits, sets
// both size registers to 8 and drops any pending response. No clearing pass.
// ============================================================================
module simplex_tableau_pivot_engine_top
    import stpe_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cmd_valid,
    output logic       cmd_stall,
    input  cmd_t       cmd,
    output logic       rsp_valid,
    input  logic       rsp_stall,
    output rsp_t       rsp,
    input  logic       cfg_we,
    input  logic [0:0] cfg_index,
    input  logic [3:0] cfg_data
);

    logic [3:0] rows_in_use_reg;
    logic [3:0] cols_in_use_reg;
    logic       rsp_valid_reg;
    rsp_t       rsp_reg;

    core_stat_t core_stat;
    rsp_t       core_res;
    logic       go;
    logic       take;

    assign go   = cmd_valid && !core_stat.busy;
    assign take = core_stat.res_valid && (!rsp_valid_reg || !rsp_stall);

    stpe_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (go),
        .cmd   (cmd),
        .nr    (eff_rows(rows_in_use_reg)),
        .nc    (eff_cols(cols_in_use_reg)),
        .take  (take),
        .res   (core_res),
        .stat  (core_stat)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_in_use_reg <= 4'd8;
            cols_in_use_reg <= 4'd8;
            rsp_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we && (cfg_index == CFG_ROWS))
                rows_in_use_reg <= cfg_data;
            if (cfg_we && (cfg_index == CFG_COLS))
                cols_in_use_reg <= cfg_data;
            if (take)
                rsp_valid_reg <= 1'b1;
            else if (!rsp_stall)
                rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            rsp_reg <= core_res;
    end

    assign cmd_stall = core_stat.busy;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // A taken command always starts work.
    a_go_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && !cmd_stall |=> cmd_stall)
        else $error("command taken but engine not busy");

    // A finished result is never offered while the engine reports idle.
    a_res_busy: assert property (@(posedge clk) disable iff (!rst_n)
        core_stat.res_valid |-> core_stat.busy)
        else $error("result offered while idle");

    // A result moved into the response register is shown on the next cycle.
    a_take_shown: assert property (@(posedge clk) disable iff (!rst_n)
        take |=> rsp_valid)
        else $error("taken result not presented");

endmodule
